/* rtl/ir_timing_stream_decoder_top_assert.svh */
// assertion macros used by the checker file
`ifndef IR_TIMING_STREAM_DECODER_TOP_ASSERT_SVH
`define IR_TIMING_STREAM_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define ITSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ITSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/itsd_pkg.sv */
`default_nettype none

package itsd_pkg;

  localparam int DURATION_BITS = 24;
  localparam int UNIT_BITS     = 32;
  localparam int RES_BITS      = 10;
  localparam int PROD_BITS     = UNIT_BITS + RES_BITS;

  localparam logic [RES_BITS-1:0] RES_RESET = RES_BITS'(61);

  // bit of the high byte that marks a space
  localparam int SPACE_BIT = 7;

  typedef enum logic [2:0] {
    PH_LOW  = 3'd0,
    PH_HIGH = 3'd1,
    PH_EXT0 = 3'd2,
    PH_EXT1 = 3'd3,
    PH_EXT2 = 3'd4,
    PH_EXT3 = 3'd5
  } phase_t;

  // one parsed timing word, still in time units
  typedef struct packed {
    logic                 is_pulse;
    logic [UNIT_BITS-1:0] units;
  } word_t;

endpackage

`default_nettype wire

/* rtl/itsd_parser.sv */
`default_nettype none

module itsd_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           byte_valid,
  output logic                byte_stall,
  input  wire logic [7:0]     data_byte,
  input  wire logic           packet_end,
  output logic                word_valid,
  output itsd_pkg::word_t     word,
  input  wire logic           word_take
);

  itsd_pkg::phase_t phase, phase_next;
  logic [7:0]  held_low_byte;
  logic        held_mark_flag;
  logic [23:0] extended_bytes, extended_bytes_next;
  logic        accept;
  logic        low_load, mark_load, emit;
  logic        high_pulse;
  logic [14:0] short_units;
  itsd_pkg::word_t emit_word;

  assign byte_stall  = word_valid && !word_take;
  assign accept      = byte_valid && !byte_stall;
  assign high_pulse  = !data_byte[itsd_pkg::SPACE_BIT];
  assign short_units = {data_byte[6:0], held_low_byte};

  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase) inside
        itsd_pkg::PH_HIGH: begin
          phase_next = (short_units != '0) ? itsd_pkg::PH_LOW : itsd_pkg::PH_EXT0;
        end
        itsd_pkg::PH_EXT0: phase_next = packet_end ? itsd_pkg::PH_EXT0 : itsd_pkg::PH_EXT1;
        itsd_pkg::PH_EXT1: phase_next = packet_end ? itsd_pkg::PH_EXT0 : itsd_pkg::PH_EXT2;
        itsd_pkg::PH_EXT2: phase_next = packet_end ? itsd_pkg::PH_EXT0 : itsd_pkg::PH_EXT3;
        itsd_pkg::PH_EXT3: phase_next = itsd_pkg::PH_LOW;
        default:           phase_next = packet_end ? itsd_pkg::PH_LOW : itsd_pkg::PH_HIGH;
      endcase
    end
  end

  always_comb begin
    low_load            = 1'b0;
    mark_load           = 1'b0;
    emit                = 1'b0;
    extended_bytes_next = extended_bytes;
    emit_word.is_pulse  = high_pulse;
    emit_word.units     = {17'd0, short_units};
    unique case (phase) inside
      itsd_pkg::PH_HIGH: begin
        if (short_units != '0) begin
          emit = 1'b1;
        end else begin
          mark_load           = 1'b1;
          extended_bytes_next = '0;
        end
      end
      itsd_pkg::PH_EXT0: begin
        extended_bytes_next = packet_end ? 24'd0 : {16'd0, data_byte};
      end
      itsd_pkg::PH_EXT1: begin
        extended_bytes_next = packet_end ? 24'd0 : {8'd0, data_byte, extended_bytes[7:0]};
      end
      itsd_pkg::PH_EXT2: begin
        extended_bytes_next = packet_end ? 24'd0 : {data_byte, extended_bytes[15:0]};
      end
      itsd_pkg::PH_EXT3: begin
        emit                = 1'b1;
        emit_word.is_pulse  = held_mark_flag;
        emit_word.units     = {data_byte, extended_bytes};
        extended_bytes_next = '0;
      end
      default: begin
        low_load = !packet_end;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= itsd_pkg::PH_LOW;
      word_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (accept && emit) begin
        word_valid <= 1'b1;
      end else if (word_take) begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      extended_bytes <= extended_bytes_next;
      if (low_load) begin
        held_low_byte <= data_byte;
      end
      if (mark_load) begin
        held_mark_flag <= high_pulse;
      end
      if (emit) begin
        word <= emit_word;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/itsd_scaler.sv */
`default_nettype none

module itsd_scaler (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 word_valid,
  input  wire itsd_pkg::word_t                      word,
  output logic                                      word_take,
  input  wire logic [itsd_pkg::RES_BITS-1:0]        resolution,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic                                      is_pulse,
  output logic [itsd_pkg::DURATION_BITS-1:0]        duration_us
);

  logic [itsd_pkg::PROD_BITS-1:0]     product;
  logic [itsd_pkg::DURATION_BITS-1:0] clipped;

  assign word_take = word_valid && (!result_valid || !result_stall);
  assign product   = itsd_pkg::PROD_BITS'(word.units) * itsd_pkg::PROD_BITS'(resolution);
  // anything above the duration width saturates
  assign clipped   = (|product[itsd_pkg::PROD_BITS-1:itsd_pkg::DURATION_BITS])
                   ? '1 : product[itsd_pkg::DURATION_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (word_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (word_take) begin
      is_pulse    <= word.is_pulse;
      duration_us <= clipped;
    end
  end

endmodule

`default_nettype wire

/* rtl/ir_timing_stream_decoder_top.sv */
// mark/space timing stream decoder
// byte channel: byte_valid / byte_stall with data_byte and packet_end, one
//   beat per byte; pairs of bytes form little-endian 16-bit words, a zero
//   duration word pulls in a 32-bit extension from the next four bytes
// result channel: result_valid / result_stall with is_pulse and duration_us,
//   the duration scaled by tick_resolution and saturated at full scale
// config channel: cfg_valid / cfg_ready with tick_resolution; cfg_ready is
//   always high, write only while the block is idle
// throughput: one byte per cycle while byte_stall is low, set by the single parser
//   state register; a result costs two or more bytes
// result path: the edge that takes the byte completing a word loads the parser
//   word register, and the scaler then multiplies that word into the result
//   register, which raises result_valid
// reset: parsing restarts at a low byte, no result pending, resolution 61
// stall: a stalled result holds; one more word waits in the parser, after
//   which byte_stall rises in the same cycle
`default_nettype none

module ir_timing_stream_decoder_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 byte_valid,
  output logic                                      byte_stall,
  input  wire logic [7:0]                           data_byte,
  input  wire logic                                 packet_end,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic                                      is_pulse,
  output logic [itsd_pkg::DURATION_BITS-1:0]        duration_us,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [itsd_pkg::RES_BITS-1:0]        tick_resolution
);

  logic [itsd_pkg::RES_BITS-1:0] resolution;
  logic                          word_valid;
  logic                          word_take;
  itsd_pkg::word_t               word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      resolution <= itsd_pkg::RES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      resolution <= tick_resolution;
    end
  end

  itsd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .data_byte  (data_byte),
    .packet_end (packet_end),
    .word_valid (word_valid),
    .word       (word),
    .word_take  (word_take)
  );

  itsd_scaler u_scaler (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word         (word),
    .word_take    (word_take),
    .resolution   (resolution),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .is_pulse     (is_pulse),
    .duration_us  (duration_us)
  );

endmodule

`default_nettype wire

/* rtl/itsd_checker.sv */
`default_nettype none

`include "ir_timing_stream_decoder_top_assert.svh"

module itsd_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 byte_valid,
  input wire logic                                 byte_stall,
  input wire logic                                 result_valid,
  input wire logic                                 result_stall,
  input wire logic                                 is_pulse,
  input wire logic [itsd_pkg::DURATION_BITS-1:0]   duration_us
);

  // a stalled result beat holds its payload
  `ITSD_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(is_pulse) && $stable(duration_us), "stalled result changed")

  // input back-pressure only comes from a stalled result
  `ITSD_ASSERT_NOW(a_stall_source, clk, rst, byte_stall, result_valid && result_stall, "byte stall without a stalled result")

  // a fresh result needs a byte beat taken earlier
  `ITSD_ASSERT_NOW(a_result_origin, clk, rst, $rose(result_valid), $past(byte_valid && !byte_stall, 2), "result without a byte beat")

endmodule

bind ir_timing_stream_decoder_top itsd_checker u_itsd_checker (
  .clk          (clk),
  .rst          (rst),
  .byte_valid   (byte_valid),
  .byte_stall   (byte_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .is_pulse     (is_pulse),
  .duration_us  (duration_us)
);

`default_nettype wire

/* sim/ir_timing_stream_decoder_top_tb.sv */
`timescale 1ns / 100ps

module ir_timing_stream_decoder_top_tb;
  import itsd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  // extra settling after the result queue drains
  localparam int SETTLE_CYCLES = 4;
  localparam logic [DURATION_BITS-1:0] DURATION_MAX = '1;
  localparam logic [RES_BITS-1:0] RES_MAX = '1;

  typedef struct packed {
    logic                     pulse;
    logic [DURATION_BITS-1:0] duration;
  } timing_result_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     byte_valid = 1'b0;
  logic                     byte_stall;
  logic [7:0]               data_byte = '0;
  logic                     packet_end = 1'b0;
  logic                     result_valid;
  logic                     result_stall = 1'b0;
  logic                     is_pulse;
  logic [DURATION_BITS-1:0] duration_us;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [RES_BITS-1:0]      tick_resolution = RES_RESET;

  // predicted parser state and registers
  phase_t              dec_phase = PH_LOW;
  logic [7:0]          dec_low = '0;
  logic                dec_mark = 1'b0;
  logic [23:0]         dec_ext = '0;
  logic [RES_BITS-1:0] dec_res = RES_RESET;

  timing_result_t pending_timings[$];
  int mismatch_count = 0;
  int bytes_sent = 0;
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int idle_cycles = 0;
  bit ext_owed = 1'b0;

  ir_timing_stream_decoder_top DUT (
    .clk             (clk),
    .rst             (rst),
    .byte_valid      (byte_valid),
    .byte_stall      (byte_stall),
    .data_byte       (data_byte),
    .packet_end      (packet_end),
    .result_valid    (result_valid),
    .result_stall    (result_stall),
    .is_pulse        (is_pulse),
    .duration_us     (duration_us),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .tick_resolution (tick_resolution)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [DURATION_BITS-1:0] scale_duration(input logic [UNIT_BITS-1:0] units);
    logic [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(units) * PROD_BITS'(dec_res);
    if (prod > PROD_BITS'(DURATION_MAX)) return DURATION_MAX;
    return prod[DURATION_BITS-1:0];
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                     output timing_result_t res);
    logic [14:0] units;
    int k;
    res = '0;
    case (dec_phase)
      PH_HIGH: begin
        units = {b[6:0], dec_low};
        if (units != '0) begin
          dec_phase = PH_LOW;
          res = '{pulse: ~b[SPACE_BIT], duration: scale_duration(UNIT_BITS'(units))};
          return 1'b1;
        end
        // zero duration, extension follows
        dec_mark = ~b[SPACE_BIT];
        dec_ext = '0;
        dec_phase = PH_EXT0;
      end
      PH_EXT0, PH_EXT1, PH_EXT2: begin
        if (last) begin
          // cut short, start the extension again in the next packet
          dec_ext = '0;
          dec_phase = PH_EXT0;
        end else begin
          k = int'(dec_phase) - int'(PH_EXT0);
          dec_ext[8*k +: 8] = b;
          dec_phase = phase_t'(dec_phase + 3'd1);
        end
      end
      PH_EXT3: begin
        dec_phase = PH_LOW;
        res = '{pulse: dec_mark, duration: scale_duration({b, dec_ext})};
        dec_ext = '0;
        return 1'b1;
      end
      default: begin
        if (!last) begin
          dec_low = b;
          dec_phase = PH_HIGH;
        end else begin
          dec_phase = PH_LOW;
        end
      end
    endcase
    return 1'b0;
  endfunction

  function automatic logic [31:0] random_extension();
    case ($urandom_range(0, 2))
      0: return 32'($urandom_range(0, 255));
      1: return 32'($urandom_range(0, 65535));
      default: return $urandom;
    endcase
  endfunction

  // leaves valid high after the beat, the caller decides what follows
  task automatic send_byte(input logic [7:0] b, input logic last);
    timing_result_t res;
    if (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    packet_end <= last;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    if (decode_byte(b, last, res)) pending_timings.push_back(res);
  endtask

  task automatic wait_results_drained();
    byte_valid <= 1'b0;
    while (pending_timings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_resolution(input logic [RES_BITS-1:0] value);
    wait_results_drained();
    cfg_valid <= 1'b1;
    tick_resolution <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dec_res = value;
  endtask

  task automatic test_special_cases();
    // shortest mark, longest mark, longest space
    send_byte(8'h01, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    // lone trailing byte is dropped
    send_byte(8'hA5, 1'b1);
    // extended space at full scale
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    repeat (4) send_byte(8'hFF, 1'b0);
    // zero word closing the packet, then its extension cut short
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    send_byte(8'h05, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    // word straight after the extension in the same packet
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_resolution_extremes();
    logic [RES_BITS-1:0] settings[4];
    settings = '{RES_BITS'(0), RES_BITS'(1), RES_BITS'(1000), RES_MAX};
    foreach (settings[i]) begin
      write_resolution(settings[i]);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h00, 1'b1);
    end
    wait_results_drained();
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_packet();
    logic [7:0] pkt[$];
    logic [14:0] units;
    logic [31:0] ext;
    logic space;
    int choice;
    bit ended;
    ended = 1'b0;
    if (ext_owed) begin
      ext = random_extension();
      for (int i = 0; i < 4; i++) pkt.push_back(ext[8*i +: 8]);
      ext_owed = 1'b0;
    end
    repeat ($urandom_range(1, 5)) if (!ended) begin
      choice = $urandom_range(0, 99);
      space = 1'($urandom_range(0, 1));
      if (choice < 70) begin
        units = $urandom_range(0, 1) ? 15'($urandom_range(1, 255)) :
                                       15'($urandom_range(1, 32767));
        pkt.push_back(units[7:0]);
        pkt.push_back({space, units[14:8]});
      end else begin
        pkt.push_back(8'h00);
        pkt.push_back({space, 7'h00});
        if (choice < 85) begin
          ext = random_extension();
          for (int i = 0; i < 4; i++) pkt.push_back(ext[8*i +: 8]);
        end else if (choice < 92) begin
          // zero word ends the packet
          ended = 1'b1;
          ext_owed = 1'b1;
        end else begin
          // extension broken off by the packet end
          repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
          ended = 1'b1;
          ext_owed = 1'b1;
        end
      end
    end
    if (!ended && $urandom_range(0, 9) == 0) pkt.push_back(8'($urandom));
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
  endtask

  task automatic test_random_stream(input int snd_pct, input int rcv_pct,
                                    input logic [RES_BITS-1:0] res, input int count);
    int target;
    bit paused;
    paused = 1'b0;
    snd_idle_pct = snd_pct;
    rcv_stall_pct = rcv_pct;
    write_resolution(res);
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      if (!paused && bytes_sent >= target - count / 2) begin
        // hold off until the result side has caught up
        wait_results_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_packet();
    end
    wait_results_drained();
  endtask

  always @(posedge clk) begin
    result_stall <= (rcv_stall_pct > 0) && ($urandom_range(0, 99) < rcv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    timing_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_timings.size() == 0) begin
        $error("result beat with nothing expected: is_pulse %0d duration_us %0d",
               is_pulse, duration_us);
        mismatch_count++;
      end else begin
        want = pending_timings.pop_front();
        if (is_pulse !== want.pulse) begin
          $error("is_pulse: expected %0d, got %0d", want.pulse, is_pulse);
          mismatch_count++;
        end
        if (duration_us !== want.duration) begin
          $error("duration_us: expected %0d, got %0d", want.duration, duration_us);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ir_timing_stream_decoder_top regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    snd_idle_pct = 24;
    rcv_stall_pct = 68;
    write_resolution(RES_RESET);
    test_special_cases();
    test_resolution_extremes();
    test_random_stream(24, 68, RES_BITS'($urandom_range(1, 1000)), 280);
    test_random_stream(68, 24, RES_BITS'(1000), 280);
    test_random_stream(0, 0, RES_BITS'(1), 280);
    if (mismatch_count == 0) begin
      $display("ir_timing_stream_decoder_top regression: pass");
    end else begin
      $display("ir_timing_stream_decoder_top regression: fail");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/itsd_pkg.sv
rtl/itsd_parser.sv
rtl/itsd_scaler.sv
rtl/ir_timing_stream_decoder_top.sv
rtl/itsd_checker.sv
sim/ir_timing_stream_decoder_top_tb.sv
